// ===== hdl/isqrt_pkg.sv =====
// Package for the floor integer square root block.
// Holds the controller state type and the command struct.
// No dependencies.
`default_nettype none

package isqrt_pkg;

    // Iteration count: one root bit per step
    localparam int unsigned STEPS = 16;
    localparam int unsigned STEP_W = 4;
    localparam int unsigned RAD_W = 32;
    localparam int unsigned ROOT_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } isqrt_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture a new radicand and clear the root
        logic step;       // run one restoring iteration
        logic out_load;   // move the finished root into the output register
    } isqrt_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/isqrt_ctrl.sv =====
// Controller for the floor integer square root block.
// Sequences the sixteen iterations and owns the request handshakes.
// Depends on isqrt_pkg.
`default_nettype none

module isqrt_ctrl
    import isqrt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output isqrt_cmd_t cmd
);

    isqrt_state_t state_reg, state_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic last_step;

    // Output register can take a new request this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign last_step = (count_reg == STEP_W'(STEPS - 1));

    // State, counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd = '0;
        in_stall = 1'b1;
        // a waiting result leaves once taken
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                count_next = count_reg + 1'b1;
                if (last_step)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/isqrt_dp.sv =====
// Datapath for the floor integer square root block.
// Restoring digit-by-digit square root, one root bit per step.
// Depends on isqrt_pkg.
`default_nettype none

module isqrt_dp
    import isqrt_pkg::*;
(
    input  wire logic              clk,
    input  wire isqrt_cmd_t        cmd,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0] trial;

    // One restoring iteration
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
        bit_next = bit_reg >> 2;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    // Output register; on the last step take the fresh result directly
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            root_reg <= cmd.step ? res_next[ROOT_W-1:0] : res_reg[ROOT_W-1:0];
        end
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/integer_square_root_floor_top.sv =====
// Top level of the floor integer square root block.
// Joins isqrt_ctrl and isqrt_dp; depends on isqrt_pkg.
//
//   channel   dir   handshake            payload
//   input     in    in_valid/in_stall    radicand[31:0]
//   output    out   out_valid/out_stall  root[15:0]
//
// One request is worked on at a time: the accept cycle loads the radicand,
// then sixteen iterations of the shared restoring step give one root bit each,
// and no new request is accepted until the root has gone to the output register.
// The finished root sits in an output register; if it is still stalled when
// the next root is done, the controller holds until it is taken.
// Reset clears the controller only; no data state survives between requests.
`default_nettype none

module integer_square_root_floor_top
    import isqrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [ROOT_W-1:0] root
);

    isqrt_cmd_t cmd;

    isqrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    isqrt_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .radicand (radicand),
        .root     (root)
    );

    // Busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while busy");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

    // Load and step never together
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step}))
        else $error("load and step issued together");

endmodule

`default_nettype wire
